>>> rtl/core/ubxr_pkg.sv
// Shared types and codes for the UBX frame receiver.
package ubxr_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int SLOT_BYTES_DEF = 256;
  localparam int CMD_DEPTH      = 2;
  localparam int RES_DEPTH      = 2;

  localparam int OFFSET_W  = 17;
  localparam int LENGTH_W  = 16;
  localparam int ADDR_W    = 10;
  localparam int STATUS_W  = 3;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic REQ_BYTE   = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POSTED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CKA_BAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CKB_BAD  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RING_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd5;

  // Classified request handed from front to back.
  typedef struct packed {
    logic       is_report;
    logic       sync1_hit;
    logic       sync2_hit;
    logic [7:0] data;
    logic [1:0] read_slot;
  } cmd_t;

  typedef struct packed {
    logic                store_valid;
    logic [ADDR_W-1:0]   store_addr;
    logic [7:0]          store_data;
    logic [STATUS_W-1:0] frame_status;
    logic [1:0]          write_slot_now;
  } result_t;

endpackage

>>> rtl/core/ubx_frame_receiver_with_checksum.sv
// UBX frame receiver: sync, length and Fletcher-8 check, ring of frame slots.
// A beat is registered in the command queue, then parsed into the result queue (empty low).
// Throughput: one beat per cycle while the result queue is not full; the parser updates its state once per beat.
// Two-entry queues sit between front and parser and after the parser.
// Reset: synchronous rst clears both queues, the parser and the slot ring;
// sync bytes return to 0xB5 and 0x62.
module ubx_frame_receiver_with_checksum #(
  parameter int SLOT_COUNT = ubxr_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = ubxr_pkg::SLOT_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic                            req_type,
  input  logic [7:0]                      rx_byte,
  input  logic [1:0]                      read_slot,
  input  logic                            pop,
  output logic                            empty,
  output logic                            store_valid,
  output logic [ubxr_pkg::ADDR_W-1:0]     store_addr,
  output logic [7:0]                      store_data,
  output logic [ubxr_pkg::STATUS_W-1:0]   frame_status,
  output logic [1:0]                      write_slot_now
);

  ubxr_pkg::cmd_t    cmd_in;
  ubxr_pkg::cmd_t    cmd_out;
  ubxr_pkg::result_t res_in;
  ubxr_pkg::result_t res_out;
  logic              cmd_empty;
  logic              cmd_pop;
  logic              res_full;
  logic              res_push;

  ubxr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .read_slot (read_slot),
    .cmd       (cmd_in)
  );

  ubxr_fifo #(
    .WIDTH ($bits(ubxr_pkg::cmd_t)),
    .DEPTH (ubxr_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_out),
    .empty   (cmd_empty)
  );

  ubxr_back #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ubxr_fifo #(
    .WIDTH ($bits(ubxr_pkg::result_t)),
    .DEPTH (ubxr_pkg::RES_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign store_valid    = res_out.store_valid;
  assign store_addr     = res_out.store_addr;
  assign store_data     = res_out.store_data;
  assign frame_status   = res_out.frame_status;
  assign write_slot_now = res_out.write_slot_now;

endmodule

>>> rtl/core/ubxr_fifo.sv
// Small synchronous FIFO used between the receiver stages.
module ubxr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

>>> rtl/core/ubxr_front.sv
// Front end: sync registers and classification of incoming requests.
module ubxr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              req_type,
  input  logic [7:0]        rx_byte,
  input  logic [1:0]        read_slot,
  output ubxr_pkg::cmd_t    cmd
);

  logic [7:0] sync_first;
  logic [7:0] sync_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= ubxr_pkg::SYNC_FIRST_RST;
      sync_second <= ubxr_pkg::SYNC_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ubxr_pkg::CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        ubxr_pkg::CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // The user must change sync values only while idle; the block does not enforce it, and matching here assumes it.
  always_comb begin
    cmd.is_report = (req_type == ubxr_pkg::REQ_REPORT);
    cmd.sync1_hit = (rx_byte == sync_first);
    cmd.sync2_hit = (rx_byte == sync_second);
    cmd.data      = rx_byte;
    cmd.read_slot = read_slot;
  end

endmodule

>>> rtl/core/ubxr_back.sv
// Back end: frame parser, checksum, slot ring and buffer write address.
module ubxr_back #(
  parameter int SLOT_COUNT = ubxr_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_BYTES = ubxr_pkg::SLOT_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ubxr_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output ubxr_pkg::result_t res
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int CMW = (SW > 2) ? SW : 2;
  localparam int OW  = ubxr_pkg::OFFSET_W;
  localparam int LW  = ubxr_pkg::LENGTH_W;
  localparam int AW  = ubxr_pkg::ADDR_W;
  localparam logic [AW-1:0] SLOT_BYTES_LO = AW'(SLOT_BYTES);
  localparam logic [OW-1:0] OFFSET_MAX    = {OW{1'b1}};

  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN1    = 4'd4;
  localparam logic [3:0] PH_LEN2    = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CKA     = 4'd7;
  localparam logic [3:0] PH_CKB     = 4'd8;

  logic [3:0]    phase, phase_next;
  logic [OW-1:0] byte_offset, byte_offset_next;
  logic [LW-1:0] payload_length, payload_length_next;
  logic [7:0]    sum_a, sum_a_next;
  logic [7:0]    sum_b, sum_b_next;
  logic [SW-1:0] write_slot, write_slot_next;
  logic [1:0]    consumer_slot, consumer_slot_next;
  logic          overflowed, overflowed_next;

  logic [OW-1:0] cur_offset;
  logic          cur_ovf;
  logic [OW-1:0] inc_offset;
  logic          fits;
  logic [7:0]    add_a;
  logic [7:0]    add_b;
  logic [SW-1:0] slot_after;
  logic [AW-1:0] slot_base;
  logic          fire;

  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  // A class byte opens a new frame: offset and overflow start fresh.
  assign cur_offset = (phase == PH_CLASS) ? '0 : byte_offset;
  assign cur_ovf    = (phase == PH_CLASS) ? 1'b0 : overflowed;
  assign inc_offset = (cur_offset != OFFSET_MAX) ? cur_offset + 1'b1 : cur_offset;
  assign fits       = (cur_offset < OW'(SLOT_BYTES));
  assign add_a      = ((phase == PH_CLASS) ? 8'd0 : sum_a) + cmd.data;
  assign add_b      = ((phase == PH_CLASS) ? 8'd0 : sum_b) + add_a;
  assign slot_after = (write_slot == SW'(SLOT_COUNT - 1)) ? '0 : write_slot + 1'b1;
  assign slot_base  = AW'(AW'(write_slot) * SLOT_BYTES_LO);

  always_comb begin
    phase_next          = phase;
    byte_offset_next    = byte_offset;
    payload_length_next = payload_length;
    sum_a_next          = sum_a;
    sum_b_next          = sum_b;
    write_slot_next     = write_slot;
    consumer_slot_next  = consumer_slot;
    overflowed_next     = overflowed;
    res                 = '0;

    if (cmd.is_report) begin
      consumer_slot_next = cmd.read_slot;
    end else begin
      case (phase)
        PH_SYNC1: begin
          if (cmd.sync1_hit) begin
            phase_next = PH_SYNC2;
          end
        end
        PH_SYNC2: begin
          phase_next = cmd.sync2_hit ? PH_CLASS : PH_SYNC1;
        end
        PH_CLASS, PH_ID, PH_PAYLOAD: begin
          res.store_valid  = fits;
          byte_offset_next = inc_offset;
          overflowed_next  = cur_ovf | !fits;
          sum_a_next       = add_a;
          sum_b_next       = add_b;
          case (phase)
            PH_CLASS: phase_next = PH_ID;
            PH_ID:    phase_next = PH_LEN1;
            default: begin
              if (inc_offset >= OW'(payload_length) + OW'(2)) begin
                phase_next = PH_CKA;
              end
            end
          endcase
        end
        PH_LEN1: begin
          payload_length_next = LW'(cmd.data);
          sum_a_next          = add_a;
          sum_b_next          = add_b;
          phase_next          = PH_LEN2;
        end
        PH_LEN2: begin
          payload_length_next = {cmd.data, payload_length[7:0]};
          sum_a_next          = add_a;
          sum_b_next          = add_b;
          phase_next = ({cmd.data, payload_length[7:0]} == '0) ? PH_CKA : PH_PAYLOAD;
        end
        PH_CKA: begin
          if (cmd.data == sum_a) begin
            phase_next = PH_CKB;
          end else begin
            res.frame_status = ubxr_pkg::ST_CKA_BAD;
            phase_next       = PH_SYNC1;
          end
        end
        PH_CKB: begin
          if (cmd.data != sum_b) begin
            res.frame_status = ubxr_pkg::ST_CKB_BAD;
          end else if (overflowed) begin
            res.frame_status = ubxr_pkg::ST_OVERFLOW;
          end else if (CMW'(slot_after) == CMW'(consumer_slot)) begin
            res.frame_status = ubxr_pkg::ST_RING_FULL;
          end else begin
            res.frame_status = ubxr_pkg::ST_POSTED;
            write_slot_next  = slot_after;
          end
          phase_next = PH_SYNC1;
        end
        default: begin
          phase_next = PH_SYNC1;
        end
      endcase
    end

    if (res.store_valid) begin
      res.store_addr = slot_base + cur_offset[AW-1:0];
      res.store_data = cmd.data;
    end
    res.write_slot_now = 2'(write_slot_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SYNC1;
      byte_offset    <= '0;
      payload_length <= '0;
      sum_a          <= '0;
      sum_b          <= '0;
      write_slot     <= '0;
      consumer_slot  <= '0;
      overflowed     <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      byte_offset    <= byte_offset_next;
      payload_length <= payload_length_next;
      sum_a          <= sum_a_next;
      sum_b          <= sum_b_next;
      write_slot     <= write_slot_next;
      consumer_slot  <= consumer_slot_next;
      overflowed     <= overflowed_next;
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UBX frame receiver with slot ring and Fletcher-8 check.
module testbench;
  import ubxr_pkg::*;

  localparam int SLOTS       = SLOT_COUNT_DEF;
  localparam int SLOT_SIZE   = SLOT_BYTES_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BEATS = 420;

  typedef enum logic [3:0] {
    P_SYNC1, P_SYNC2, P_CLASS, P_ID, P_LEN1, P_LEN2, P_PAYLOAD, P_CKA, P_CKB
  } parse_phase_e;

  typedef enum int {F_GOOD, F_BAD_CKA, F_BAD_CKB, F_TRUNCATED, F_BAD_SYNC2} frame_fault_e;

  typedef struct packed {
    logic       req;
    logic [7:0] data;
    logic [1:0] slot;
  } rx_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic                cfg_index = CFG_SYNC_FIRST;
  logic [7:0]          cfg_data = 8'h00;
  logic                push = 1'b0;
  logic                full;
  logic                req_type = REQ_BYTE;
  logic [7:0]          rx_byte = 8'h00;
  logic [1:0]          read_slot = 2'd0;
  logic                pop = 1'b0;
  logic                empty;
  logic                store_valid;
  logic [ADDR_W-1:0]   store_addr;
  logic [7:0]          store_data;
  logic [STATUS_W-1:0] frame_status;
  logic [1:0]          write_slot_now;

  ubx_frame_receiver_with_checksum dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .req_type(req_type), .rx_byte(rx_byte), .read_slot(read_slot),
    .pop(pop), .empty(empty),
    .store_valid(store_valid), .store_addr(store_addr), .store_data(store_data),
    .frame_status(frame_status), .write_slot_now(write_slot_now)
  );

  rx_beat_t rx_beats[$];
  result_t  expected_outcomes[$];

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit mix_reports = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int results_seen = 0;
  int beats_queued = 0;
  int frames_built = 0;

  // Parser shadow state
  logic [7:0]   m_sync1 = SYNC_FIRST_RST;
  logic [7:0]   m_sync2 = SYNC_SECOND_RST;
  parse_phase_e m_phase = P_SYNC1;
  logic [16:0]  m_offset = '0;
  logic [15:0]  m_length = '0;
  logic [7:0]   m_sum_a = '0;
  logic [7:0]   m_sum_b = '0;
  logic [1:0]   m_wslot = '0;
  logic [1:0]   m_cslot = '0;
  logic         m_ovf = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void fletcher_add(logic [7:0] b);
    m_sum_a = m_sum_a + b;
    m_sum_b = m_sum_b + m_sum_a;
  endfunction

  // Write into the current slot unless the offset has run past the slot end.
  function automatic void slot_write(logic [7:0] b, inout result_t r);
    if (int'(m_offset) < SLOT_SIZE) begin
      r.store_valid = 1'b1;
      r.store_addr  = ADDR_W'(int'(m_wslot) * SLOT_SIZE + int'(m_offset));
      r.store_data  = b;
    end else begin
      m_ovf = 1'b1;
    end
    if (m_offset != 17'h1FFFF) m_offset = m_offset + 1'b1;
  endfunction

  function automatic result_t parse_rx_beat(rx_beat_t beat);
    result_t    r;
    logic [1:0] next_slot;
    r = '0;
    r.frame_status = ST_NONE;
    if (beat.req == REQ_REPORT) begin
      m_cslot = beat.slot;
    end else begin
      case (m_phase)
        P_SYNC1: if (beat.data == m_sync1) m_phase = P_SYNC2;
        P_SYNC2: m_phase = (beat.data == m_sync2) ? P_CLASS : P_SYNC1;
        P_CLASS: begin
          m_sum_a = '0;
          m_sum_b = '0;
          m_offset = '0;
          m_ovf = 1'b0;
          slot_write(beat.data, r);
          fletcher_add(beat.data);
          m_phase = P_ID;
        end
        P_ID: begin
          slot_write(beat.data, r);
          fletcher_add(beat.data);
          m_phase = P_LEN1;
        end
        P_LEN1: begin
          m_length = {8'h00, beat.data};
          fletcher_add(beat.data);
          m_phase = P_LEN2;
        end
        P_LEN2: begin
          m_length[15:8] = beat.data;
          fletcher_add(beat.data);
          m_phase = (m_length == 16'd0) ? P_CKA : P_PAYLOAD;
        end
        P_PAYLOAD: begin
          slot_write(beat.data, r);
          fletcher_add(beat.data);
          if (int'(m_offset) >= int'(m_length) + 2) m_phase = P_CKA;
        end
        P_CKA: begin
          if (beat.data == m_sum_a) begin
            m_phase = P_CKB;
          end else begin
            r.frame_status = ST_CKA_BAD;
            m_phase = P_SYNC1;
          end
        end
        P_CKB: begin
          next_slot = 2'((int'(m_wslot) + 1) % SLOTS);
          if (beat.data != m_sum_b) r.frame_status = ST_CKB_BAD;
          else if (m_ovf) r.frame_status = ST_OVERFLOW;
          else if (next_slot == m_cslot) r.frame_status = ST_RING_FULL;
          else begin
            r.frame_status = ST_POSTED;
            m_wslot = next_slot;
          end
          m_phase = P_SYNC1;
        end
        default: m_phase = P_SYNC1;
      endcase
    end
    r.write_slot_now = m_wslot;
    return r;
  endfunction

  // Sprinkle consumer reports between bytes; they leave the parser alone.
  function automatic void queue_beat(logic [7:0] b);
    rx_beat_t t;
    if (mix_reports && $urandom_range(15) == 0) begin
      t.req  = REQ_REPORT;
      t.data = 8'($urandom_range(255));
      t.slot = 2'($urandom_range(3));
      rx_beats.push_back(t);
      beats_queued++;
    end
    t.req  = REQ_BYTE;
    t.data = b;
    t.slot = 2'($urandom_range(3));
    rx_beats.push_back(t);
    beats_queued++;
  endfunction

  function automatic void queue_frame(logic [7:0] s1, logic [7:0] s2, int len,
                                      frame_fault_e fault);
    logic [7:0] body[$];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    int         cut;
    queue_beat(s1);
    if (fault == F_BAD_SYNC2) begin
      queue_beat(s2 ^ 8'($urandom_range(1, 255)));
      return;
    end
    queue_beat(s2);
    body.push_back(8'($urandom_range(255)));
    body.push_back(8'($urandom_range(255)));
    body.push_back(8'(len));
    body.push_back(8'(len >> 8));
    for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(255)));
    ck_a = '0;
    ck_b = '0;
    foreach (body[i]) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    if (fault == F_BAD_CKA) ck_a = ck_a ^ 8'($urandom_range(1, 255));
    if (fault == F_BAD_CKB) ck_b = ck_b ^ 8'($urandom_range(1, 255));
    body.push_back(ck_a);
    body.push_back(ck_b);
    // cut only after the length bytes so the parser never sees a stray length
    cut = (fault == F_TRUNCATED) ? $urandom_range(4, body.size() - 1) : body.size();
    for (int i = 0; i < cut; i++) queue_beat(body[i]);
  endfunction

  function automatic void queue_random(int count, logic [7:0] s1, logic [7:0] s2);
    int           start;
    int           pick;
    int           len;
    frame_fault_e fault;
    start = beats_queued;
    while (beats_queued - start < count) begin
      if ($urandom_range(99) < 80) begin
        frames_built++;
        len = (frames_built % 23 == 5) ? $urandom_range(253, 258) : $urandom_range(0, 12);
        pick = $urandom_range(99);
        fault = (pick < 70) ? F_GOOD : (pick < 78) ? F_BAD_CKA : (pick < 86) ? F_BAD_CKB :
                (pick < 94) ? F_TRUNCATED : F_BAD_SYNC2;
        queue_frame(s1, s2, len, fault);
      end else begin
        repeat ($urandom_range(1, 6)) queue_beat(8'($urandom_range(255)));
      end
    end
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= 100) $display("ERROR: %s", msg);
  endtask

  task automatic check_outcome();
    result_t want;
    if (expected_outcomes.size() == 0) begin
      note_error($sformatf("result %0d arrived with nothing expected", results_seen));
    end else begin
      want = expected_outcomes.pop_front();
      if (store_valid !== want.store_valid)
        note_error($sformatf("result %0d store_valid %b, expected %b",
                             results_seen, store_valid, want.store_valid));
      if (store_addr !== want.store_addr)
        note_error($sformatf("result %0d store_addr %0d, expected %0d",
                             results_seen, store_addr, want.store_addr));
      if (store_data !== want.store_data)
        note_error($sformatf("result %0d store_data %0h, expected %0h",
                             results_seen, store_data, want.store_data));
      if (frame_status !== want.frame_status)
        note_error($sformatf("result %0d frame_status %0d, expected %0d",
                             results_seen, frame_status, want.frame_status));
      if (write_slot_now !== want.write_slot_now)
        note_error($sformatf("result %0d write_slot_now %0d, expected %0d",
                             results_seen, write_slot_now, want.write_slot_now));
    end
    results_seen++;
  endtask

  // Both sync registers, back to back; only called while the block is idle.
  task automatic set_syncs(logic [7:0] s1, logic [7:0] s2);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_SYNC_FIRST;
    cfg_data <= s1;
    m_sync1 = s1;
    @(posedge clk);
    cfg_index <= CFG_SYNC_SECOND;
    cfg_data <= s2;
    m_sync2 = s2;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (rx_beats.size() != 0 || expected_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: advance on an accepted beat, then offer the next one or idle.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) expected_outcomes.push_back(parse_rx_beat(rx_beats.pop_front()));
      if (rx_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        push <= 1'b1;
        req_type <= rx_beats[0].req;
        rx_byte <= rx_beats[0].data;
        read_slot <= rx_beats[0].slot;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: check each popped beat; one long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_outcome();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) ||
        (rx_beats.size() == 0 && expected_outcomes.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] s1;
    logic [7:0] s2;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
          s1 = SYNC_FIRST_RST;
          s2 = SYNC_SECOND_RST;
        end
        1: begin
          sender_idle_pct = 86;
          receiver_stall_pct = 0;
          s1 = 8'h00;
          s2 = 8'hFF;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 86;
          s1 = 8'hFF;
          s2 = 8'h00;
        end
        default: begin
          sender_idle_pct = 16;
          receiver_stall_pct = 16;
          s1 = 8'($urandom_range(255));
          s2 = 8'($urandom_range(255));
        end
      endcase
      if (p != 0) set_syncs(s1, s2);
      if (p == 0) begin
        // consumer report, second sync mismatch, then the frame end cases
        mix_reports = 1'b0;
        rx_beats.push_back('{REQ_REPORT, 8'h00, 2'd3});
        queue_beat(s1);
        queue_beat(s1);
        queue_frame(s1, s2, 0, F_GOOD);
        queue_frame(s1, s2, 0, F_BAD_CKA);
        queue_frame(s1, s2, 1, F_BAD_CKB);
        mix_reports = 1'b1;
      end
      queue_random(PHASE_BEATS / 2, s1, s2);
      if (p == 0) hold_go <= 1'b1;
      // let the ring catch up before the second half
      wait_drained();
      queue_random(PHASE_BEATS / 2, s1, s2);
      wait_drained();
    end
    repeat (8) @(posedge clk);
    if (expected_outcomes.size() != 0) note_error("results still missing at the end");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
